### rtl/array_tree_traversal_defines.svh
// Assertion macros shared by the array tree traversal checkers.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ARRAY_TREE_TRAVERSAL_DEFINES_SVH
`define ARRAY_TREE_TRAVERSAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/att_pkg.sv
// Shared constants, codes and types of the array tree traversal block.
// No dependencies; the RTL modules and the checker refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package att_pkg;

	// Fixed field widths of the ports.
	localparam int DATA_W      = 32;
	localparam int SLOT_PORT_W = 6;
	localparam int LIMIT_W     = 7;

	// Parameter defaults.
	localparam int CAPACITY_DEF     = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Reset value of the slots-in-use register.
	localparam logic [LIMIT_W-1:0] SLOTS_RESET = 7'd64;

	// Item kinds.
	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_WALK  = 1'b1;

	// Walk orders.
	localparam logic [1:0] ORD_LEVEL = 2'd0;
	localparam logic [1:0] ORD_PRE   = 2'd1;
	localparam logic [1:0] ORD_IN    = 2'd2;
	localparam logic [1:0] ORD_POST  = 2'd3;

	// Events from the walk sequencer to the result stage.
	typedef struct packed {
		logic emit;   // a node is visited in output order this cycle
		logic done;   // the walk has finished
	} walk_ev_t;

endpackage

### rtl/att_store.sv
// Payload memory and occupancy flags of the implicit binary tree.
// Depends on att_pkg for port widths.
`timescale 1ns / 1ps

module att_store #(
	parameter int CAPACITY     = att_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = att_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [att_pkg::SLOT_PORT_W-1:0]      wr_slot,
	input  logic [att_pkg::DATA_W-1:0]           wr_payload,
	input  logic                                 rd_en,
	input  logic [$clog2(CAPACITY)-1:0]          rd_addr,
	output logic [PAYLOAD_BITS-1:0]              rd_data,
	output logic [CAPACITY-1:0]                  occ
);

	localparam int SLOT_W = $clog2(CAPACITY);

	logic [PAYLOAD_BITS-1:0] mem_q [CAPACITY];
	logic [PAYLOAD_BITS-1:0] rd_data_q;
	logic [CAPACITY-1:0]     occ_q;
	logic                    in_range;
	logic                    wr_go;
	logic [SLOT_W-1:0]       wr_addr;

	// Stores beyond the capacity are dropped.
	assign in_range = ({1'b0, wr_slot} < (att_pkg::SLOT_PORT_W + 1)'(CAPACITY));
	assign wr_go    = wr_en && in_range;
	assign wr_addr  = SLOT_W'(wr_slot);

	// Synchronous payload memory, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_addr] <= PAYLOAD_BITS'({{att_pkg::DATA_W{1'b0}}, wr_payload});
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Occupancy flags, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (wr_go) begin
			occ_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;
	assign occ     = occ_q;

endmodule

### rtl/att_walker.sv
// Walk sequencer: level-order slot scan and depth-first walk over an explicit stack.
// Depends on att_pkg for order codes and the event struct.
`timescale 1ns / 1ps

module att_walker #(
	parameter int CAPACITY = att_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              walk_go,
	input  logic [1:0]                        order,
	input  logic [att_pkg::LIMIT_W-1:0]       slots_in_use,
	input  logic [CAPACITY-1:0]               occ,
	output att_pkg::walk_ev_t                 ev,
	output logic [$clog2(CAPACITY)-1:0]       ev_slot,
	output logic                              busy
);

	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int LIM_W     = $clog2(CAPACITY + 1);
	localparam int STK_DEPTH = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(STK_DEPTH);
	localparam int SP_W      = $clog2(STK_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LEVEL = 2'd1;
	localparam logic [1:0] ST_DFS   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// Frame phases: left subtree next, right subtree next, leaving the node.
	localparam logic [1:0] PH_LEFT  = 2'd0;
	localparam logic [1:0] PH_RIGHT = 2'd1;
	localparam logic [1:0] PH_UP    = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        order_q;
	logic [LIM_W-1:0]  limit_q;
	logic [SLOT_W-1:0] scan_q;
	logic [CAPACITY-1:0] reach_q;
	logic [SLOT_W-1:0] stk_node_q [STK_DEPTH];
	logic [1:0]        stk_ph_q   [STK_DEPTH];
	logic [SP_W-1:0]   sp_q;

	logic [LIM_W-1:0]  lim_sat;
	logic              root_ok;
	logic [SLOT_W-1:0] par;
	logic              scan_hit;
	logic [SLOT_W:0]   scan_nxt;
	logic              scan_end;
	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  push_idx;
	logic [SLOT_W-1:0] top_node;
	logic [1:0]        top_ph;
	logic [SLOT_W+1:0] child;
	logic              child_ok;
	logic              dfs_emit;

	// Limit saturated to the capacity, taken at walk start.
	assign lim_sat = (slots_in_use > att_pkg::LIMIT_W'(CAPACITY))
		? LIM_W'(CAPACITY) : LIM_W'(slots_in_use);
	assign root_ok = (lim_sat != '0) && occ[0];

	// Level order: a slot is reached when occupied and its parent was reached.
	assign par      = (scan_q - SLOT_W'(1)) >> 1;
	assign scan_hit = occ[scan_q] && ((scan_q == '0) || reach_q[par]);
	assign scan_nxt = {1'b0, scan_q} + (SLOT_W + 1)'(1);
	assign scan_end = (scan_nxt == (SLOT_W + 1)'(limit_q));

	// Depth-first step on the top frame; only reachable children are pushed.
	// The child index has two spare bits so the children of the deepest slot never wrap.
	assign top_idx  = IDX_W'(sp_q - SP_W'(1));
	assign push_idx = IDX_W'(sp_q);
	assign top_node = stk_node_q[top_idx];
	assign top_ph   = stk_ph_q[top_idx];
	assign child    = {1'b0, top_node, 1'b0} + ((top_ph == PH_LEFT) ? (SLOT_W + 2)'(1)
		: (SLOT_W + 2)'(2));
	assign child_ok = (child < (SLOT_W + 2)'(limit_q)) && occ[child[SLOT_W-1:0]];

	always_comb begin
		case (top_ph)
			PH_LEFT:  dfs_emit = (order_q == att_pkg::ORD_PRE);
			PH_RIGHT: dfs_emit = (order_q == att_pkg::ORD_IN);
			default:  dfs_emit = (order_q == att_pkg::ORD_POST);
		endcase
	end

	// Sequencer state, scan position, reach flags and stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= att_pkg::ORD_LEVEL;
			limit_q <= '0;
			scan_q  <= '0;
			reach_q <= '0;
			sp_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (walk_go) begin
						order_q <= order;
						limit_q <= lim_sat;
						scan_q  <= '0;
						reach_q <= '0;
						if (order == att_pkg::ORD_LEVEL) begin
							state_q <= (lim_sat == '0) ? ST_DONE : ST_LEVEL;
						end else if (root_ok) begin
							sp_q    <= SP_W'(1);
							state_q <= ST_DFS;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LEVEL: begin
					reach_q[scan_q] <= scan_hit;
					scan_q          <= scan_nxt[SLOT_W-1:0];
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DFS: begin
					if (top_ph == PH_UP) begin
						sp_q <= sp_q - SP_W'(1);
						if (sp_q == SP_W'(1)) begin
							state_q <= ST_DONE;
						end
					end else if (child_ok) begin
						sp_q <= sp_q + SP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stack frames.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && walk_go) begin
			stk_node_q[0] <= '0;
			stk_ph_q[0]   <= PH_LEFT;
		end else if (state_q == ST_DFS && top_ph != PH_UP) begin
			stk_ph_q[top_idx] <= (top_ph == PH_LEFT) ? PH_RIGHT : PH_UP;
			if (child_ok) begin
				stk_node_q[push_idx] <= child[SLOT_W-1:0];
				stk_ph_q[push_idx]   <= PH_LEFT;
			end
		end
	end

	// Events toward the result stage.
	always_comb begin
		ev.emit = 1'b0;
		ev.done = (state_q == ST_DONE);
		ev_slot = scan_q;
		if (state_q == ST_LEVEL) begin
			ev.emit = scan_hit;
		end else if (state_q == ST_DFS) begin
			ev.emit = dfs_emit;
			ev_slot = top_node;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/att_emitter.sv
// Result stage: holds one visited node back so the final one can carry the last flag.
// Depends on att_pkg for the event struct; reads payloads through the store's read port.
`timescale 1ns / 1ps

module att_emitter #(
	parameter int CAPACITY = att_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  att_pkg::walk_ev_t             ev,
	input  logic [$clog2(CAPACITY)-1:0]   ev_slot,
	output logic                          rd_en,
	output logic [$clog2(CAPACITY)-1:0]   rd_addr,
	output logic                          res_strobe,
	output logic [$clog2(CAPACITY)-1:0]   res_slot,
	output logic                          res_found,
	output logic                          res_last
);

	localparam int SLOT_W = $clog2(CAPACITY);

	logic              pend_vld_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic              strobe_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              found_s1;
	logic              last_s1;
	logic              release_go;

	// The held node leaves when another node follows it or the walk ends.
	assign release_go = pend_vld_q && (ev.emit || ev.done);
	assign rd_en      = release_go;
	assign rd_addr    = pend_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			strobe_s1  <= 1'b0;
			found_s1   <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			if (ev.emit) begin
				pend_vld_q <= 1'b1;
			end else if (ev.done) begin
				pend_vld_q <= 1'b0;
			end
			strobe_s1 <= release_go || ev.done;
			found_s1  <= pend_vld_q;
			last_s1   <= ev.done;
		end
	end

	// Slot of the held node and of the beat in flight.
	always_ff @(posedge clk) begin
		if (ev.emit) begin
			pend_slot_q <= ev_slot;
		end
		slot_s1 <= pend_vld_q ? pend_slot_q : '0;
	end

	assign res_strobe = strobe_s1;
	assign res_slot   = slot_s1;
	assign res_found  = found_s1;
	assign res_last   = last_s1;

endmodule

### rtl/array_tree_traversal.sv
// Top level of the array tree traversal block: config register, store, walker, result stage.
// Depends on att_pkg, att_store, att_walker and att_emitter.
//
//   Channel  Handshake                   Payload
//   item     start / busy                kind, slot, payload, order
//   result   result_strobe (no stall)    node_slot, node_payload, found, last
//   config   cfg_wen                     cfg_data (slots_in_use)
//
// A store item keeps busy low, so stores may come every cycle while no walk runs.
// A level-order walk holds busy while it scans slots below the saturated slots_in_use;
// a depth-first walk while the stack sequencer steps each reachable node's frame through
// its phases; both end in a done state. A visited node is held until the next visit or
// the done cycle and its beat shows in the next cycle; the final beat shows in the first
// cycle with busy low. Reset clears the occupancy flags at once; the receiver cannot stall.
`timescale 1ns / 1ps

module array_tree_traversal #(
	parameter int CAPACITY     = att_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = att_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [att_pkg::SLOT_PORT_W-1:0]      slot,
	input  logic [att_pkg::DATA_W-1:0]           payload,
	input  logic [1:0]                           order,
	input  logic                                 cfg_wen,
	input  logic [att_pkg::LIMIT_W-1:0]          cfg_data,
	output logic                                 result_strobe,
	output logic [att_pkg::SLOT_PORT_W-1:0]      node_slot,
	output logic [att_pkg::DATA_W-1:0]           node_payload,
	output logic                                 found,
	output logic                                 last
);

	localparam int SLOT_W = $clog2(CAPACITY);

	logic [att_pkg::LIMIT_W-1:0] slots_in_use_q;
	logic                        accept;
	logic                        store_go;
	logic                        walk_go;
	logic                        walk_busy;
	logic [CAPACITY-1:0]         occ;
	att_pkg::walk_ev_t           ev;
	logic [SLOT_W-1:0]           ev_slot;
	logic                        rd_en;
	logic [SLOT_W-1:0]           rd_addr;
	logic [PAYLOAD_BITS-1:0]     rd_data;
	logic [SLOT_W-1:0]           res_slot;

	// Item acceptance and dispatch.
	assign accept   = start && !walk_busy;
	assign store_go = accept && (kind == att_pkg::KIND_STORE);
	assign walk_go  = accept && (kind == att_pkg::KIND_WALK);
	assign busy     = walk_busy;

	// Slots-in-use register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= att_pkg::SLOTS_RESET;
		end else if (cfg_wen) begin
			slots_in_use_q <= cfg_data;
		end
	end

	att_store #(
		.CAPACITY     (CAPACITY),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (store_go),
		.wr_slot    (slot),
		.wr_payload (payload),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.occ        (occ)
	);

	att_walker #(
		.CAPACITY (CAPACITY)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.walk_go      (walk_go),
		.order        (order),
		.slots_in_use (slots_in_use_q),
		.occ          (occ),
		.ev           (ev),
		.ev_slot      (ev_slot),
		.busy         (walk_busy)
	);

	att_emitter #(
		.CAPACITY (CAPACITY)
	) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev),
		.ev_slot    (ev_slot),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.res_strobe (result_strobe),
		.res_slot   (res_slot),
		.res_found  (found),
		.res_last   (last)
	);

	// Result fields; the empty-walk beat carries zeros.
	assign node_slot    = att_pkg::SLOT_PORT_W'(res_slot);
	assign node_payload = found ? att_pkg::DATA_W'(rd_data) : '0;

endmodule

### rtl/att_checker.sv
// Port-level checker for the array tree traversal block, bound to the top level.
// Depends on att_pkg and the assertion macros in array_tree_traversal_defines.svh.
`timescale 1ns / 1ps
`include "array_tree_traversal_defines.svh"

module att_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 kind,
	input logic                                 result_strobe,
	input logic [att_pkg::SLOT_PORT_W-1:0]      node_slot,
	input logic [att_pkg::DATA_W-1:0]           node_payload,
	input logic                                 found,
	input logic                                 last
);

	// An empty-walk beat is the final beat and carries zeros.
	`ATT_ASSERT_IMP(a_empty_is_last, clk, arst_n, result_strobe && !found, last)
	`ATT_ASSERT_IMP(a_empty_zero, clk, arst_n, result_strobe && !found, node_slot == '0 && node_payload == '0)

	// A store leaves the block free; a walk occupies it.
	`ATT_ASSERT_NXT(a_store_free, clk, arst_n, start && !busy && kind == att_pkg::KIND_STORE, !busy)
	`ATT_ASSERT_NXT(a_walk_busy, clk, arst_n, start && !busy && kind == att_pkg::KIND_WALK, busy)

	// Nothing follows the final beat of a walk in the next cycle.
	`ATT_ASSERT_NXT(a_gap_after_last, clk, arst_n, result_strobe && last, !result_strobe)

endmodule

bind array_tree_traversal att_checker u_att_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.result_strobe (result_strobe),
	.node_slot     (node_slot),
	.node_payload  (node_payload),
	.found         (found),
	.last          (last)
);

### tb/tb_array_tree_traversal.sv
// Self-checking testbench for the array tree traversal block: stores build a tree, walks
// are predicted in all four orders and checked beat by beat. Depends on att_pkg and the RTL.
`timescale 1ns / 1ps

module tb_array_tree_traversal;
	import att_pkg::*;

	localparam int CAPACITY      = CAPACITY_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RAND_PHASES   = 11;
	localparam int PHASE_ITEMS   = 30;

	// Steps of one depth-first frame: visit left subtree, visit right subtree, retire.
	localparam int STEP_LEFT  = 0;
	localparam int STEP_RIGHT = 1;
	localparam int STEP_DONE  = 2;

	typedef struct packed {
		logic [SLOT_PORT_W-1:0] slot_no;
		logic [DATA_W-1:0]      word;
		logic                   found;
		logic                   last;
	} node_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   kind = KIND_STORE;
	logic [SLOT_PORT_W-1:0] slot = '0;
	logic [DATA_W-1:0]      payload = '0;
	logic [1:0]             order = ORD_LEVEL;
	logic                   cfg_wen = 1'b0;
	logic [LIMIT_W-1:0]     cfg_data = '0;
	logic                   result_strobe;
	logic [SLOT_PORT_W-1:0] node_slot;
	logic [DATA_W-1:0]      node_payload;
	logic                   found;
	logic                   last;

	// Shadow copy of the tree and the slots-in-use register.
	logic [DATA_W-1:0]  tree_data [CAPACITY];
	bit                 tree_used [CAPACITY];
	logic [LIMIT_W-1:0] slots_limit = SLOTS_RESET;

	node_beat_t pending_beats [$];
	node_beat_t beat_want;
	int         error_count = 0;
	int         cycle_count;
	bit         gaps_on = 1'b1;

	array_tree_traversal dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.slot          (slot),
		.payload       (payload),
		.order         (order),
		.cfg_wen       (cfg_wen),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.node_slot     (node_slot),
		.node_payload  (node_payload),
		.found         (found),
		.last          (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Work out the beats of one walk over the shadow tree and queue them in order.
	task automatic predict_walk(input logic [1:0] ord);
		int lim, s, sp, top, step, child;
		int frame_slot [8];
		int frame_step [8];
		bit reach [CAPACITY];
		int visits [$];
		node_beat_t b;
		lim = (slots_limit > CAPACITY) ? CAPACITY : int'(slots_limit);
		if (ord == ORD_LEVEL) begin
			// Ascending slots; a node counts only when its parent did.
			for (s = 0; s < lim; s++) begin
				reach[s] = tree_used[s] && (s == 0 || reach[(s - 1) / 2]);
				if (reach[s])
					visits.push_back(s);
			end
		end else if (lim > 0 && tree_used[0]) begin
			// Depth-first walk with an explicit frame stack.
			sp = 1;
			frame_slot[0] = 0;
			frame_step[0] = STEP_LEFT;
			while (sp > 0) begin
				top = frame_slot[sp - 1];
				step = frame_step[sp - 1];
				frame_step[sp - 1] = step + 1;
				if (step == STEP_DONE) begin
					if (ord == ORD_POST)
						visits.push_back(top);
					sp--;
				end else begin
					if ((step == STEP_LEFT && ord == ORD_PRE) ||
					    (step == STEP_RIGHT && ord == ORD_IN))
						visits.push_back(top);
					child = 2 * top + 1 + step;
					if (child < lim && tree_used[child]) begin
						frame_slot[sp] = child;
						frame_step[sp] = STEP_LEFT;
						sp++;
					end
				end
			end
		end
		if (visits.size() == 0) begin
			b = '{slot_no: '0, word: '0, found: 1'b0, last: 1'b1};
			pending_beats.push_back(b);
		end
		for (s = 0; s < visits.size(); s++) begin
			b.slot_no = visits[s][SLOT_PORT_W-1:0];
			b.word    = tree_data[visits[s]];
			b.found   = 1'b1;
			b.last    = (s == visits.size() - 1);
			pending_beats.push_back(b);
		end
	endtask

	// Present one item, hold it until accepted, then update the prediction.
	task automatic send_item(input logic k, input logic [SLOT_PORT_W-1:0] s,
			input logic [DATA_W-1:0] p, input logic [1:0] o);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start   <= 1'b1;
		kind    <= k;
		slot    <= s;
		payload <= p;
		order   <= o;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (k == KIND_STORE) begin
			tree_data[s] = p;
			tree_used[s] = 1'b1;
		end else begin
			predict_walk(o);
		end
	endtask

	task automatic store_node(input logic [SLOT_PORT_W-1:0] s, input logic [DATA_W-1:0] p);
		send_item(KIND_STORE, s, p, 2'($urandom_range(0, 3)));
	endtask

	// Walk items carry random slot and payload bits, which the block must ignore.
	task automatic walk_tree(input logic [1:0] o);
		send_item(KIND_WALK, 6'($urandom_range(0, 63)), $urandom, o);
	endtask

	// Wait until every expected beat has arrived and the block is idle.
	task automatic drain(input int extra);
		start <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0 || busy)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain(SETTLE_CYCLES);
		cfg_wen  <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		slots_limit = v;
	endtask

	// Every order on the empty tree after reset gives the single not-found beat.
	task automatic test_empty_walks();
		walk_tree(ORD_LEVEL);
		walk_tree(ORD_PRE);
		walk_tree(ORD_IN);
		walk_tree(ORD_POST);
	endtask

	// A left spine down to the deepest slot, a right child, an orphan and an overwrite.
	task automatic test_deep_chain();
		store_node(6'd0, 32'h0000_0000);
		store_node(6'd1, $urandom);
		store_node(6'd3, $urandom);
		store_node(6'd7, $urandom);
		store_node(6'd15, $urandom);
		store_node(6'd31, $urandom);
		store_node(6'd63, 32'hFFFF_FFFF);
		store_node(6'd2, $urandom);
		store_node(6'd40, $urandom);
		store_node(6'd0, 32'hFFFF_FFFF);
		walk_tree(ORD_LEVEL);
		walk_tree(ORD_PRE);
		walk_tree(ORD_IN);
		walk_tree(ORD_POST);
	endtask

	// Zero limit empties the tree, one keeps the root, large values saturate.
	task automatic test_limit_extremes();
		write_limit(7'd0);
		walk_tree(ORD_PRE);
		write_limit(7'd1);
		walk_tree(ORD_IN);
		write_limit(7'd127);
		walk_tree(ORD_POST);
		write_limit(7'd63);
		walk_tree(ORD_LEVEL);
	endtask

	// Phases of random stores and walks, each under a fresh limit; stores mostly grow
	// the tree below occupied parents, the rest land anywhere.
	task automatic test_random_traffic();
		int phase, n, t, s;
		logic [LIMIT_W-1:0] lim;
		logic [DATA_W-1:0] p;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case ($urandom_range(0, 5))
				0: lim = 7'($urandom_range(1, 7));
				1: lim = 7'($urandom_range(8, 31));
				2, 3: lim = 7'($urandom_range(32, 64));
				4: lim = 7'($urandom_range(65, 127));
				default: lim = $urandom_range(0, 1) ? 7'd0 : 7'd64;
			endcase
			write_limit(lim);
			gaps_on = (phase < RAND_PHASES - 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 6) begin
					s = $urandom_range(0, 63);
					if ($urandom_range(0, 9) < 7)
						for (t = 0; t < 16 && s != 0 && !tree_used[(s - 1) / 2]; t++)
							s = $urandom_range(0, 63);
					case ($urandom_range(0, 7))
						0: p = '0;
						1: p = '1;
						default: p = $urandom;
					endcase
					store_node(6'(s), p);
				end else begin
					walk_tree(2'($urandom_range(0, 3)));
				end
			end
		end
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got slot %0d payload %h found %b last %b",
					$time, node_slot, node_payload, found, last);
				error_count++;
			end else begin
				beat_want = pending_beats.pop_front();
				if (node_slot !== beat_want.slot_no) begin
					$display("%0t: node_slot expected %0d, got %0d",
						$time, beat_want.slot_no, node_slot);
					error_count++;
				end
				if (node_payload !== beat_want.word) begin
					$display("%0t: node_payload expected %h, got %h",
						$time, beat_want.word, node_payload);
					error_count++;
				end
				if (found !== beat_want.found) begin
					$display("%0t: found expected %b, got %b", $time, beat_want.found, found);
					error_count++;
				end
				if (last !== beat_want.last) begin
					$display("%0t: last expected %b, got %b", $time, beat_want.last, last);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("%0t: timeout with %0d beats still expected", $time, pending_beats.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_walks();
		test_deep_chain();
		test_limit_extremes();
		test_random_traffic();
		drain(DRAIN_CYCLES);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
